>>> rtl/mlp_sigmoid_inference_defines.svh
// Assertion macros used by the perceptron inference top level.
// No dependencies; included by files that carry concurrent checks.
`ifndef MLP_SIGMOID_INFERENCE_DEFINES_SVH
`define MLP_SIGMOID_INFERENCE_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle
`define MSI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("msi same-cycle check failed");

// Check that an antecedent implies a consequent in the next cycle
`define MSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("msi next-cycle check failed");

`endif

>>> rtl/msi_pkg.sv
// Shared constants, types and the sigmoid table for the perceptron inference block.
// No dependencies; used by the modules under rtl other than msi_ram.
`timescale 1ns / 1ps
package msi_pkg;

    localparam int NUM_INPUTS  = 4;
    localparam int NUM_HIDDEN  = 8;
    localparam int NUM_OUTPUTS = 2;
    localparam int SIG_DEPTH   = 1024;

    // lane and store layout
    localparam int LANES     = NUM_INPUTS;
    localparam int LANE_BITS = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int OUT_STEPS = (NUM_HIDDEN + LANES - 1) / LANES;
    localparam int HB_BASE   = NUM_HIDDEN * NUM_INPUTS;
    localparam int OW_BASE   = HB_BASE + NUM_HIDDEN;
    localparam int OB_BASE   = OW_BASE + NUM_OUTPUTS * NUM_HIDDEN;
    localparam int STORE_DEPTH = OB_BASE + NUM_OUTPUTS;
    localparam int W_ROWS    = NUM_HIDDEN + NUM_OUTPUTS * OUT_STEPS;
    localparam int B_ROWS    = NUM_HIDDEN + NUM_OUTPUTS;
    localparam int ROW_W     = (W_ROWS > 1) ? $clog2(W_ROWS) : 1;
    localparam int BROW_W    = (B_ROWS > 1) ? $clog2(B_ROWS) : 1;
    localparam int HID_W     = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
    localparam int OUT_W     = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

    // field widths
    localparam int IDX_W   = 6;
    localparam int WGT_W   = 16;
    localparam int FEAT_W  = 8;
    localparam int SCORE_W = 16;
    localparam int PROD_W  = WGT_W + SCORE_W + 1;
    localparam int ACC_W   = 36;
    localparam int LUT_AW  = $clog2(SIG_DEPTH);

    // fixed-point alignment
    localparam int HID_BIAS_SH = FEAT_W;
    localparam int OUT_BIAS_SH = SCORE_W;
    localparam int HID_FRAC    = 12 + FEAT_W;
    localparam int OUT_FRAC    = 12 + SCORE_W;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_INFER = 1'b1;

    // pipeline tag that travels with each lane request
    typedef struct packed {
        logic             vld;
        logic             is_out;
        logic             first;
        logic             last;
        logic [OUT_W-1:0] neuron;
    } t_tag;

    typedef logic [SCORE_W-1:0] t_lut [SIG_DEPTH];

    // shift-subtract quotient, used only while building the table
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned dvs);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= dvs) begin
                rem    = rem - dvs;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // one table entry: sigmoid at the bin midpoint, Q0.16, rounded
    function automatic logic [SCORE_W-1:0] sig_entry(int unsigned k);
        longint unsigned odd, mag, t, n, f, term, sum, e, den, q;
        bit              neg;
        odd  = 64'(2 * k + 1);
        neg  = odd < 64'(SIG_DEPTH);
        mag  = neg ? 64'(8) * (64'(SIG_DEPTH) - odd) : 64'(8) * (odd - 64'(SIG_DEPTH));
        t    = div_u64(mag << 32, 64'(SIG_DEPTH));
        n    = t >> 32;
        f    = t & 64'hFFFF_FFFF;
        term = 64'h1_0000_0000;
        sum  = 64'h1_0000_0000;
        for (int unsigned j = 1; j <= 24; j++) begin
            term = div_u64((term * f) >> 32, 64'(j));
            if (j[0]) sum = sum - term;
            else sum = sum + term;
        end
        e = sum;
        for (int unsigned j = 0; (64'(j) < n) && (j < 16); j++) begin
            e = (e * 64'd1580030169) >> 32;
        end
        den = 64'h1_0000_0000 + e;
        if (!neg) q = div_u64((64'd1 << 48) + (den >> 1), den);
        else q = div_u64((e << 16) + (den >> 1), den);
        if (q > 64'd65535) q = 64'd65535;
        return q[SCORE_W-1:0];
    endfunction

    function automatic t_lut build_lut();
        t_lut l;
        for (int k = 0; k < SIG_DEPTH; k++) begin
            l[k] = sig_entry(k);
        end
        return l;
    endfunction

    localparam t_lut SIG_LUT = build_lut();

endpackage

>>> rtl/msi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module msi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/msi_lane.sv
// One MAC lane: signed weight times unsigned operand, registered product.
// Depends on msi_pkg.
`timescale 1ns / 1ps
module msi_lane (
    input  logic                                 i_clk,
    input  logic [msi_pkg::WGT_W-1:0]            i_w,
    input  logic [msi_pkg::SCORE_W-1:0]          i_x,
    output logic signed [msi_pkg::PROD_W-1:0]    o_prod
);

    logic signed [msi_pkg::PROD_W-1:0] r_prod;

    // multiply and hold product for the merge stage
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_w) * $signed({1'b0, i_x});
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/msi_merge.sv
// Merge stage: adds the lane products and the bias, accumulates over steps.
// Depends on msi_pkg.
`timescale 1ns / 1ps
module msi_merge (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic signed [msi_pkg::PROD_W-1:0]     i_prod [msi_pkg::LANES],
    input  logic [msi_pkg::WGT_W-1:0]             i_bias,
    input  msi_pkg::t_tag                         i_tag,
    output logic signed [msi_pkg::ACC_W-1:0]      o_acc,
    output msi_pkg::t_tag                         o_tag
);

    logic signed [msi_pkg::ACC_W-1:0] r_acc;
    logic signed [msi_pkg::ACC_W-1:0] n_acc;
    logic signed [msi_pkg::ACC_W-1:0] bias_term;
    logic signed [msi_pkg::ACC_W-1:0] lane_sum;
    msi_pkg::t_tag                    r_tag;

    // align bias to the layer's fraction and sum the lanes
    always_comb begin
        bias_term = msi_pkg::ACC_W'($signed(i_bias));
        if (i_tag.is_out) bias_term = bias_term <<< msi_pkg::OUT_BIAS_SH;
        else bias_term = bias_term <<< msi_pkg::HID_BIAS_SH;
        lane_sum = '0;
        for (int l = 0; l < msi_pkg::LANES; l++) begin
            lane_sum = lane_sum + msi_pkg::ACC_W'(i_prod[l]);
        end
        n_acc = (i_tag.first ? bias_term : r_acc) + lane_sum;
    end

    // advance accumulator on each request
    always_ff @(posedge i_clk) begin
        if (i_tag.vld) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    assign o_acc = r_acc;
    assign o_tag = r_tag;

endmodule

>>> rtl/msi_act.sv
// Activation: saturate the pre-activation, index and look up the sigmoid table.
// Depends on msi_pkg.
`timescale 1ns / 1ps
module msi_act (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [msi_pkg::ACC_W-1:0]     i_acc,
    input  msi_pkg::t_tag                        i_tag,
    output logic [msi_pkg::SCORE_W-1:0]          o_act,
    output msi_pkg::t_tag                        o_tag,
    output logic                                 o_busy
);

    localparam logic signed [msi_pkg::ACC_W-1:0] HID_LIM =
        msi_pkg::ACC_W'(64'sd8 <<< msi_pkg::HID_FRAC);
    localparam logic signed [msi_pkg::ACC_W-1:0] OUT_LIM =
        msi_pkg::ACC_W'(64'sd8 <<< msi_pkg::OUT_FRAC);

    logic signed [msi_pkg::ACC_W-1:0] sat_h;
    logic signed [msi_pkg::ACC_W-1:0] sat_o;
    logic [msi_pkg::ACC_W-1:0]        off_h;
    logic [msi_pkg::ACC_W-1:0]        off_o;
    logic [msi_pkg::LUT_AW-1:0]       n_idx;
    logic [msi_pkg::LUT_AW-1:0]       r_idx;
    logic [msi_pkg::SCORE_W-1:0]      r_act;
    msi_pkg::t_tag                    n_tag1;
    msi_pkg::t_tag                    r_tag1;
    msi_pkg::t_tag                    r_tag2;

    // saturate to [-8, 8) and take the top bits of the offset value
    always_comb begin
        if (i_acc < -HID_LIM) sat_h = -HID_LIM;
        else if (i_acc > HID_LIM - 1) sat_h = HID_LIM - 1;
        else sat_h = i_acc;
        if (i_acc < -OUT_LIM) sat_o = -OUT_LIM;
        else if (i_acc > OUT_LIM - 1) sat_o = OUT_LIM - 1;
        else sat_o = i_acc;
        off_h = sat_h + HID_LIM;
        off_o = sat_o + OUT_LIM;
        if (i_tag.is_out) n_idx = off_o[msi_pkg::OUT_FRAC+3 -: msi_pkg::LUT_AW];
        else n_idx = off_h[msi_pkg::HID_FRAC+3 -: msi_pkg::LUT_AW];
        n_tag1     = i_tag;
        n_tag1.vld = i_tag.vld && i_tag.last;
    end

    // index stage, then table stage
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_act <= msi_pkg::SIG_LUT[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= n_tag1;
            r_tag2 <= r_tag1;
        end
    end

    assign o_act  = r_act;
    assign o_tag  = r_tag2;
    // flag any completed sum still inside either stage
    assign o_busy = r_tag1.vld || r_tag2.vld;

endmodule

>>> rtl/mlp_sigmoid_inference.sv
// An infer request runs from acceptance to the result register in these steps:
// hidden issues (one neuron per cycle on the four MAC lanes), a pipe drain,
// output-layer issues, another drain, and the load of the result register.
// A new request is accepted only while idle, so the next infer or load waits until
// the current infer has delivered its result; a load request is written on acceptance.
// Reset (synchronous, active low) clears control only; the weight store is not cleared.
`timescale 1ns / 1ps
`include "mlp_sigmoid_inference_defines.svh"
module mlp_sigmoid_inference (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic [msi_pkg::IDX_W-1:0]          i_weight_index,
    input  logic signed [msi_pkg::WGT_W-1:0]   i_weight_value,
    input  logic [msi_pkg::FEAT_W-1:0]         i_feature_0,
    input  logic [msi_pkg::FEAT_W-1:0]         i_feature_1,
    input  logic [msi_pkg::FEAT_W-1:0]         i_feature_2,
    input  logic [msi_pkg::FEAT_W-1:0]         i_feature_3,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_predicted_class,
    output logic [msi_pkg::SCORE_W-1:0]        o_confidence,
    output logic [msi_pkg::SCORE_W-1:0]        o_score_first,
    output logic [msi_pkg::SCORE_W-1:0]        o_score_second
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_HID     = 6'b000010,
        S_DRAIN_H = 6'b000100,
        S_OUT     = 6'b001000,
        S_DRAIN_O = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic [msi_pkg::HID_W-1:0]      r_cnt;
    logic [msi_pkg::HID_W-1:0]      n_cnt;
    logic [msi_pkg::OUT_W-1:0]      r_o;
    logic [msi_pkg::OUT_W-1:0]      n_o;
    msi_pkg::t_tag                  issue_tag;
    msi_pkg::t_tag                  r_tag_rd;
    msi_pkg::t_tag                  r_tag_mul;
    msi_pkg::t_tag                  merge_tag;
    msi_pkg::t_tag                  act_tag;
    logic                           act_busy;
    logic                           in_acc;
    logic                           pipe_empty;
    logic                           out_free;

    logic [msi_pkg::FEAT_W-1:0]     r_feat [msi_pkg::LANES];
    logic [msi_pkg::SCORE_W-1:0]    r_hid [msi_pkg::NUM_HIDDEN];
    logic [msi_pkg::SCORE_W-1:0]    r_score [msi_pkg::NUM_OUTPUTS];

    // weight store write decode
    logic                           is_hw;
    logic                           is_hb;
    logic                           is_ow;
    logic                           is_ob;
    logic                           ow_hi;
    logic [msi_pkg::IDX_W-1:0]      ow_off;
    logic [msi_pkg::IDX_W-1:0]      ow_h;
    logic [msi_pkg::LANE_BITS-1:0]  w_bank;
    logic [msi_pkg::ROW_W-1:0]      w_row;
    logic [msi_pkg::BROW_W-1:0]     b_row;
    logic                           load_acc;
    logic [msi_pkg::ROW_W-1:0]      rd_row;
    logic [msi_pkg::BROW_W-1:0]     rd_brow;

    logic [msi_pkg::WGT_W-1:0]      bank_rdata [msi_pkg::LANES];
    logic [msi_pkg::WGT_W-1:0]      bias_rdata;
    logic [msi_pkg::WGT_W-1:0]      r_bias_mul;
    logic [msi_pkg::SCORE_W-1:0]    lane_x [msi_pkg::LANES];
    logic signed [msi_pkg::PROD_W-1:0] lane_prod [msi_pkg::LANES];
    logic signed [msi_pkg::ACC_W-1:0]  merge_acc;
    logic [msi_pkg::SCORE_W-1:0]    act_val;

    logic                           r_out_valid;
    logic                           r_class;
    logic [msi_pkg::SCORE_W-1:0]    r_conf;
    logic [msi_pkg::SCORE_W-1:0]    r_sf;
    logic [msi_pkg::SCORE_W-1:0]    r_ss;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign load_acc   = in_acc && (i_opcode == msi_pkg::OP_LOAD);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign pipe_empty = !r_tag_rd.vld && !r_tag_mul.vld && !merge_tag.vld && !act_tag.vld
                        && !act_busy && (r_state != S_HID) && (r_state != S_OUT);

    // decode a load index into bank, row and bias row
    always_comb begin
        is_hw  = i_weight_index < msi_pkg::IDX_W'(msi_pkg::HB_BASE);
        is_hb  = !is_hw && (i_weight_index < msi_pkg::IDX_W'(msi_pkg::OW_BASE));
        is_ow  = (i_weight_index >= msi_pkg::IDX_W'(msi_pkg::OW_BASE))
                 && (i_weight_index < msi_pkg::IDX_W'(msi_pkg::OB_BASE));
        is_ob  = (i_weight_index >= msi_pkg::IDX_W'(msi_pkg::OB_BASE))
                 && (i_weight_index < msi_pkg::IDX_W'(msi_pkg::STORE_DEPTH));
        ow_off = i_weight_index - msi_pkg::IDX_W'(msi_pkg::OW_BASE);
        ow_hi  = ow_off >= msi_pkg::IDX_W'(msi_pkg::NUM_HIDDEN);
        ow_h   = ow_hi ? ow_off - msi_pkg::IDX_W'(msi_pkg::NUM_HIDDEN) : ow_off;
        if (is_hw) begin
            w_bank = i_weight_index[msi_pkg::LANE_BITS-1:0];
            w_row  = msi_pkg::ROW_W'(i_weight_index >> msi_pkg::LANE_BITS);
        end else begin
            w_bank = ow_h[msi_pkg::LANE_BITS-1:0];
            w_row  = msi_pkg::ROW_W'(msi_pkg::NUM_HIDDEN
                     + (ow_hi ? msi_pkg::OUT_STEPS : 0)
                     + int'(ow_h >> msi_pkg::LANE_BITS));
        end
        if (is_hb) b_row = msi_pkg::BROW_W'(i_weight_index - msi_pkg::IDX_W'(msi_pkg::HB_BASE));
        else b_row = msi_pkg::BROW_W'(i_weight_index - msi_pkg::IDX_W'(msi_pkg::OB_BASE)
                     + msi_pkg::IDX_W'(msi_pkg::NUM_HIDDEN));
    end

    // read rows for the current issue
    always_comb begin
        if (r_state == S_OUT) begin
            rd_row  = msi_pkg::ROW_W'(msi_pkg::NUM_HIDDEN + int'(r_o) * msi_pkg::OUT_STEPS
                      + int'(r_cnt));
            rd_brow = msi_pkg::BROW_W'(msi_pkg::NUM_HIDDEN + int'(r_o));
        end else begin
            rd_row  = msi_pkg::ROW_W'(r_cnt);
            rd_brow = msi_pkg::BROW_W'(r_cnt);
        end
    end

    // weight banks, one per lane, and the bias store
    for (genvar l = 0; l < msi_pkg::LANES; l++) begin : g_bank
        msi_ram #(
            .WIDTH (msi_pkg::WGT_W),
            .DEPTH (msi_pkg::W_ROWS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (load_acc && (is_hw || is_ow)
                      && (w_bank == msi_pkg::LANE_BITS'(l))),
            .i_waddr (w_row),
            .i_wdata (i_weight_value),
            .i_raddr (rd_row),
            .o_rdata (bank_rdata[l])
        );
    end

    msi_ram #(
        .WIDTH (msi_pkg::WGT_W),
        .DEPTH (msi_pkg::B_ROWS)
    ) u_bias (
        .i_clk   (i_clk),
        .i_we    (load_acc && (is_hb || is_ob)),
        .i_waddr (b_row),
        .i_wdata (i_weight_value),
        .i_raddr (rd_brow),
        .o_rdata (bias_rdata)
    );

    // sequencer: hidden pass, drain, output pass, drain, deliver
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_o       = r_o;
        issue_tag = '0;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                n_o   = '0;
                if (in_acc && (i_opcode == msi_pkg::OP_INFER)) n_state = S_HID;
            end
            S_HID: begin
                issue_tag.vld   = 1'b1;
                issue_tag.first = 1'b1;
                issue_tag.last  = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == msi_pkg::HID_W'(msi_pkg::NUM_HIDDEN - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN_H;
                end
            end
            S_DRAIN_H: begin
                if (pipe_empty) n_state = S_OUT;
            end
            S_OUT: begin
                issue_tag.vld    = 1'b1;
                issue_tag.is_out = 1'b1;
                issue_tag.first  = (r_cnt == '0);
                issue_tag.last   = (r_cnt == msi_pkg::HID_W'(msi_pkg::OUT_STEPS - 1));
                issue_tag.neuron = r_o;
                n_cnt = r_cnt + 1'b1;
                if (issue_tag.last) begin
                    n_cnt = '0;
                    n_o   = r_o + 1'b1;
                    if (r_o == msi_pkg::OUT_W'(msi_pkg::NUM_OUTPUTS - 1)) n_state = S_DRAIN_O;
                end
            end
            S_DRAIN_O: begin
                if (pipe_empty) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o       <= '0;
            r_tag_rd  <= '0;
            r_tag_mul <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o       <= n_o;
            r_tag_rd  <= issue_tag;
            r_tag_mul <= r_tag_rd;
        end
    end

    // capture features on an accepted infer request
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_opcode == msi_pkg::OP_INFER)) begin
            r_feat[0] <= i_feature_0;
            r_feat[1] <= i_feature_1;
            r_feat[2] <= i_feature_2;
            r_feat[3] <= i_feature_3;
        end
        r_bias_mul <= bias_rdata;
    end

    // lane operands: features in the hidden pass, hidden taps in the output pass
    always_comb begin
        for (int l = 0; l < msi_pkg::LANES; l++) begin
            if (r_tag_rd.is_out) lane_x[l] = r_hid[l];
            else lane_x[l] = msi_pkg::SCORE_W'(r_feat[l]);
        end
    end

    for (genvar l = 0; l < msi_pkg::LANES; l++) begin : g_lane
        msi_lane u_lane (
            .i_clk  (i_clk),
            .i_w    (bank_rdata[l]),
            .i_x    (lane_x[l]),
            .o_prod (lane_prod[l])
        );
    end

    msi_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prod  (lane_prod),
        .i_bias  (r_bias_mul),
        .i_tag   (r_tag_mul),
        .o_acc   (merge_acc),
        .o_tag   (merge_tag)
    );

    msi_act u_act (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (merge_acc),
        .i_tag   (merge_tag),
        .o_act   (act_val),
        .o_tag   (act_tag),
        .o_busy  (act_busy)
    );

    // shift in hidden activations; rotate the taps as the output pass consumes them
    always_ff @(posedge i_clk) begin
        if (act_tag.vld && !act_tag.is_out) begin
            r_hid[msi_pkg::NUM_HIDDEN-1] <= act_val;
            for (int j = 0; j < msi_pkg::NUM_HIDDEN - 1; j++) begin
                r_hid[j] <= r_hid[j+1];
            end
        end else if (r_tag_rd.vld && r_tag_rd.is_out) begin
            for (int j = 0; j < msi_pkg::NUM_HIDDEN; j++) begin
                r_hid[j] <= r_hid[msi_pkg::HID_W'((j + msi_pkg::LANES < msi_pkg::NUM_HIDDEN)
                                ? j + msi_pkg::LANES
                                : j + msi_pkg::LANES - msi_pkg::NUM_HIDDEN)];
            end
        end
        if (act_tag.vld && act_tag.is_out) begin
            r_score[act_tag.neuron] <= act_val;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_class <= !(r_score[0] > r_score[1]);
            r_conf  <= (r_score[0] > r_score[1]) ? r_score[0] - r_score[1]
                                                 : r_score[1] - r_score[0];
            r_sf    <= r_score[0];
            r_ss    <= r_score[1];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_predicted_class = r_class;
    assign o_confidence      = r_conf;
    assign o_score_first     = r_sf;
    assign o_score_second    = r_ss;

    // checks
    `MSI_ASSERT_NEXT(a_infer_starts, i_clk, i_rst_n, in_acc && (i_opcode == msi_pkg::OP_INFER), r_state == S_HID)
    `MSI_ASSERT_SAME(a_hid_phase, i_clk, i_rst_n, act_tag.vld && !act_tag.is_out, r_state == S_HID || r_state == S_DRAIN_H)
    `MSI_ASSERT_NEXT(a_deliver, i_clk, i_rst_n, (r_state == S_DONE) && out_free, o_out_valid && (r_state == S_IDLE))

endmodule

>>> bench/mlp_sigmoid_inference_tb.sv
// Self-checking testbench for the 4-8-2 sigmoid perceptron inference block.
// Depends on msi_pkg (widths, opcodes, store layout) and on mlp_sigmoid_inference.
`timescale 1ns / 1ps
module mlp_sigmoid_inference_tb;

    localparam int STALL_PCT  = 18;
    localparam int IDLE_LIMIT = 5000;
    localparam int RAND_ITEMS = 830;

    typedef struct {
        logic                        cls;
        logic [msi_pkg::SCORE_W-1:0] conf;
        logic [msi_pkg::SCORE_W-1:0] first;
        logic [msi_pkg::SCORE_W-1:0] second;
    } t_score;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic                               i_opcode = msi_pkg::OP_LOAD;
    logic [msi_pkg::IDX_W-1:0]          i_weight_index = '0;
    logic signed [msi_pkg::WGT_W-1:0]   i_weight_value = '0;
    logic [msi_pkg::FEAT_W-1:0]         i_feature_0 = '0;
    logic [msi_pkg::FEAT_W-1:0]         i_feature_1 = '0;
    logic [msi_pkg::FEAT_W-1:0]         i_feature_2 = '0;
    logic [msi_pkg::FEAT_W-1:0]         i_feature_3 = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic                               o_predicted_class;
    logic [msi_pkg::SCORE_W-1:0]        o_confidence;
    logic [msi_pkg::SCORE_W-1:0]        o_score_first;
    logic [msi_pkg::SCORE_W-1:0]        o_score_second;

    logic signed [msi_pkg::WGT_W-1:0]   weights [msi_pkg::STORE_DEPTH];
    logic [msi_pkg::SCORE_W-1:0]        sigmoid_tab [msi_pkg::SIG_DEPTH];
    t_score                             score_q [$];
    int                                 mismatches = 0;
    int                                 idle_cycles = 0;
    bit                                 idling_on = 1'b1;

    mlp_sigmoid_inference u_top (.*);

    always #5 i_clk = ~i_clk;

    // Sigmoid at the midpoint of bin k, Q0.16, from an integer e^-x series
    function automatic logic [msi_pkg::SCORE_W-1:0] sigmoid_bin(int k);
        longint unsigned odd, mag, t, n, f, term, sum, e, den, q;
        bit              neg;
        odd = 2 * k + 1;
        neg = odd < msi_pkg::SIG_DEPTH;
        mag = neg ? 8 * (msi_pkg::SIG_DEPTH - odd) : 8 * (odd - msi_pkg::SIG_DEPTH);
        t = (mag << 32) / msi_pkg::SIG_DEPTH;
        n = t >> 32;
        f = t & 64'hFFFF_FFFF;
        term = 64'h1_0000_0000;
        sum = term;
        for (int j = 1; j <= 24; j++) begin
            term = ((term * f) >> 32) / j;
            if (j % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        e = sum;
        for (int j = 0; j < n && j < 16; j++) e = (e * 64'd1580030169) >> 32;
        den = 64'h1_0000_0000 + e;
        if (!neg) q = ((64'd1 << 48) + den / 2) / den;
        else q = ((e << 16) + den / 2) / den;
        if (q > 65535) q = 65535;
        return q[msi_pkg::SCORE_W-1:0];
    endfunction

    // Saturate to [-8,8) and look up the table
    function automatic logic [msi_pkg::SCORE_W-1:0] squash(longint acc, int frac);
        longint lim;
        longint idx;
        lim = longint'(8) << frac;
        if (acc < -lim) acc = -lim;
        if (acc > lim - 1) acc = lim - 1;
        idx = ((acc + lim) * msi_pkg::SIG_DEPTH) >>> (frac + 4);
        if (idx > msi_pkg::SIG_DEPTH - 1) idx = msi_pkg::SIG_DEPTH - 1;
        return sigmoid_tab[idx];
    endfunction

    function automatic t_score forward_pass(logic [msi_pkg::FEAT_W-1:0] f0,
                                            logic [msi_pkg::FEAT_W-1:0] f1,
                                            logic [msi_pkg::FEAT_W-1:0] f2,
                                            logic [msi_pkg::FEAT_W-1:0] f3);
        longint                      feat [msi_pkg::NUM_INPUTS];
        logic [msi_pkg::SCORE_W-1:0] hid [msi_pkg::NUM_HIDDEN];
        logic [msi_pkg::SCORE_W-1:0] outs [msi_pkg::NUM_OUTPUTS];
        longint                      acc;
        t_score                      r;
        feat[0] = f0; feat[1] = f1; feat[2] = f2; feat[3] = f3;
        for (int h = 0; h < msi_pkg::NUM_HIDDEN; h++) begin
            acc = longint'(weights[msi_pkg::HB_BASE + h]) * 256;
            for (int i = 0; i < msi_pkg::NUM_INPUTS; i++)
                acc += longint'(weights[h * msi_pkg::NUM_INPUTS + i]) * feat[i];
            hid[h] = squash(acc, msi_pkg::HID_FRAC);
        end
        for (int o = 0; o < msi_pkg::NUM_OUTPUTS; o++) begin
            acc = longint'(weights[msi_pkg::OB_BASE + o]) * 65536;
            for (int h = 0; h < msi_pkg::NUM_HIDDEN; h++)
                acc += longint'(weights[msi_pkg::OW_BASE + o * msi_pkg::NUM_HIDDEN + h])
                       * longint'(hid[h]);
            outs[o] = squash(acc, msi_pkg::OUT_FRAC);
        end
        r.cls = (outs[0] > outs[1]) ? 1'b0 : 1'b1;
        r.conf = (outs[0] > outs[1]) ? outs[0] - outs[1] : outs[1] - outs[0];
        r.first = outs[0];
        r.second = outs[1];
        return r;
    endfunction

    // Offer a request, hold until taken, then predict or store; ends at a negedge
    task automatic send_request(logic op, logic [msi_pkg::IDX_W-1:0] idx,
                                logic [msi_pkg::WGT_W-1:0] val,
                                logic [msi_pkg::FEAT_W-1:0] f0, logic [msi_pkg::FEAT_W-1:0] f1,
                                logic [msi_pkg::FEAT_W-1:0] f2, logic [msi_pkg::FEAT_W-1:0] f3);
        int gap;
        if (idling_on && $urandom_range(99) < STALL_PCT) begin
            gap = $urandom_range(1, 4);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode = op;
        i_weight_index = idx;
        i_weight_value = val;
        i_feature_0 = f0;
        i_feature_1 = f1;
        i_feature_2 = f2;
        i_feature_3 = f3;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (op == msi_pkg::OP_INFER) score_q = {score_q, forward_pass(f0, f1, f2, f3)};
        else if (idx < msi_pkg::STORE_DEPTH) weights[idx] = val;
        @(negedge i_clk);
    endtask

    task automatic load_weight(int idx, logic [msi_pkg::WGT_W-1:0] val);
        send_request(msi_pkg::OP_LOAD, msi_pkg::IDX_W'(idx), val,
                     msi_pkg::FEAT_W'($urandom), msi_pkg::FEAT_W'($urandom),
                     msi_pkg::FEAT_W'($urandom), msi_pkg::FEAT_W'($urandom));
    endtask

    task automatic infer(logic [msi_pkg::FEAT_W-1:0] f0, logic [msi_pkg::FEAT_W-1:0] f1,
                         logic [msi_pkg::FEAT_W-1:0] f2, logic [msi_pkg::FEAT_W-1:0] f3);
        send_request(msi_pkg::OP_INFER, msi_pkg::IDX_W'($urandom), msi_pkg::WGT_W'($urandom),
                     f0, f1, f2, f3);
    endtask

    task automatic infer_random();
        infer(msi_pkg::FEAT_W'($urandom), msi_pkg::FEAT_W'($urandom),
              msi_pkg::FEAT_W'($urandom), msi_pkg::FEAT_W'($urandom));
    endtask

    // Drop valid and hold until every pending result has drained
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (score_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [msi_pkg::WGT_W-1:0] rand_weight();
        if ($urandom_range(2) == 0) return msi_pkg::WGT_W'($urandom);
        return msi_pkg::WGT_W'($signed($urandom_range(0, 12288)) - 6144);
    endfunction

    task automatic test_load_store();
        for (int k = 0; k < msi_pkg::STORE_DEPTH; k++) load_weight(k, rand_weight());
        load_weight(0, 16'sh8000);
        load_weight(msi_pkg::STORE_DEPTH - 1, 16'sh7FFF);
    endtask

    task automatic test_feature_extremes();
        infer(8'h00, 8'h00, 8'h00, 8'h00);
        infer(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        infer(8'hFF, 8'h00, 8'hFF, 8'h00);
    endtask

    // Saturate every pre-activation high, then low
    task automatic test_saturation();
        for (int k = 0; k < msi_pkg::STORE_DEPTH; k++) load_weight(k, 16'sh7FFF);
        infer(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        for (int k = 0; k < msi_pkg::STORE_DEPTH; k++) load_weight(k, 16'sh8000);
        infer(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    endtask

    // Equal scores must pick class 1 with zero confidence
    task automatic test_tie();
        for (int k = msi_pkg::OW_BASE; k < msi_pkg::STORE_DEPTH; k++) load_weight(k, 16'sh0000);
        infer_random();
    endtask

    // Out-of-range loads are dropped and must not disturb the store
    task automatic test_ignored_fields();
        for (int k = msi_pkg::STORE_DEPTH; k < 64; k++)
            load_weight(k, msi_pkg::WGT_W'($urandom));
        send_request(msi_pkg::OP_INFER, 6'h3F, 16'hFFFF, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
        send_request(msi_pkg::OP_INFER, 6'h00, 16'h0000, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
    endtask

    task automatic test_random();
        int pick;
        for (int k = 0; k < msi_pkg::STORE_DEPTH; k++) load_weight(k, rand_weight());
        for (int n = 0; n < RAND_ITEMS; n++) begin
            idling_on = !(n >= 400 && n < 600);
            if (n == 700) drain_results();
            pick = $urandom_range(99);
            if (pick < 65) infer_random();
            else if (pick < 95)
                load_weight($urandom_range(0, msi_pkg::STORE_DEPTH - 1), rand_weight());
            else
                load_weight($urandom_range(msi_pkg::STORE_DEPTH, 63),
                            msi_pkg::WGT_W'($urandom));
        end
        idling_on = 1'b1;
    endtask

    // Stall the result channel at random
    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && idling_on && ($urandom_range(99) < STALL_PCT);
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_score want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (score_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: class %0d scores %h %h",
                    o_predicted_class, o_score_first, o_score_second);
            end else begin
                want = score_q.pop_front();
                if (o_predicted_class !== want.cls || o_confidence !== want.conf ||
                    o_score_first !== want.first || o_score_second !== want.second) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp cls %0d conf %h s0 %h s1 %h, got %0d %h %h %h",
                            want.cls, want.conf, want.first, want.second, o_predicted_class,
                            o_confidence, o_score_first, o_score_second);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        for (int k = 0; k < msi_pkg::SIG_DEPTH; k++) sigmoid_tab[k] = sigmoid_bin(k);
        for (int k = 0; k < msi_pkg::STORE_DEPTH; k++) weights[k] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_load_store();
        test_feature_extremes();
        test_saturation();
        test_tie();
        test_ignored_fields();
        test_random();
        drain_results();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && score_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
